### rtl/lzss_pkg.sv
// Shared types for the LZSS stream decoder: sequencer states, token phases
// and bit reader operations. No dependencies.
package lzss_pkg;

  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_COPY,
    ST_DONE
  } st_t;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_LEN,
    PH_DIST
  } phase_t;

  typedef enum logic [2:0] {
    BR_NOP,
    BR_LOAD,
    BR_FLAG,
    BR_LIT,
    BR_LEN,
    BR_DIST,
    BR_CLEAR
  } br_op_t;

endpackage

### rtl/lzss_bitrd.sv
// Bit reader: accumulator of unconsumed compressed bits, oldest in bit 0.
// Appends one byte, drops the bits of one token field or clears all bits, per cycle. Uses lzss_pkg.
module lzss_bitrd
  import lzss_pkg::*;
#(
  parameter int WINDOW_BITS = 12,
  parameter int LENGTH_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  br_op_t               op,
  input  logic [BYTE_W-1:0]    in_byte,
  output logic [WINDOW_BITS+7:0] acc,
  output logic [$clog2(WINDOW_BITS+9)-1:0] held
);

  localparam int ACC_W  = WINDOW_BITS + 8;
  localparam int HELD_W = $clog2(WINDOW_BITS + 9);

  logic [ACC_W-1:0]  acc_next;
  logic [HELD_W-1:0] held_next;

  always_comb begin
    acc_next  = acc;
    held_next = held;
    case (op)
      BR_LOAD: begin
        acc_next  = acc | (ACC_W'(in_byte) << held);
        held_next = held + HELD_W'(BYTE_W);
      end
      BR_FLAG: begin
        acc_next  = acc >> 1;
        held_next = held - HELD_W'(1);
      end
      BR_LIT: begin
        acc_next  = acc >> BYTE_W;
        held_next = held - HELD_W'(BYTE_W);
      end
      BR_LEN: begin
        acc_next  = acc >> LENGTH_BITS;
        held_next = held - HELD_W'(LENGTH_BITS);
      end
      BR_DIST: begin
        acc_next  = acc >> WINDOW_BITS;
        held_next = held - HELD_W'(WINDOW_BITS);
      end
      BR_CLEAR: begin
        acc_next  = '0;
        held_next = '0;
      end
      default: begin
        acc_next  = acc;
        held_next = held;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      held <= '0;
    end else begin
      acc  <= acc_next;
      held <= held_next;
    end
  end

endmodule

### rtl/lzss_window.sv
// Ring window: one append port at the write pointer, one registered read port.
// Entries not yet written read as zero; a same-cycle write is forwarded. Uses lzss_pkg.
module lzss_window
  import lzss_pkg::*;
#(
  parameter int WINDOW_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [BYTE_W-1:0]      push_data,
  input  logic                   rd_en,
  input  logic [WINDOW_BITS-1:0] rd_addr,
  output logic [WINDOW_BITS-1:0] wp,
  output logic [BYTE_W-1:0]      rd_data
);

  localparam int DEPTH = 1 << WINDOW_BITS;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] mem_q;
  logic [BYTE_W-1:0] fwd_data;
  logic              fwd;
  logic              live;
  logic              wrapped;

  // Writes only ever go in order from address zero, so an entry holds data
  // once the pointer has passed it or the window has wrapped.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (push) begin
      wp <= wp + WINDOW_BITS'(1);
      if (wp == {WINDOW_BITS{1'b1}}) begin
        wrapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd      <= push && (rd_addr == wp);
      fwd_data <= push_data;
      live     <= wrapped || (rd_addr < wp);
    end
  end

  assign rd_data = fwd ? fwd_data : (live ? mem_q : '0);

endmodule

### rtl/lzss_stream_decoder.sv
// LZSS stream decoder top: sequencer, bit reader, ring window, output register.
// Depends on lzss_pkg, lzss_bitrd and lzss_window.
//
// Takes one compressed byte per word and decodes it LSB first: a 0 flag and
// an 8-bit literal, or a 1 flag, a LENGTH_BITS length code and a WINDOW_BITS
// backward distance that copies code + MATCH_OFFSET + 1 bytes from the ring
// window; the all-ones code ends the stream with one marker word (tuser[1])
// and all later input is dropped until reset. Input is accepted only between
// bytes: after a byte is loaded the sequencer decodes one flag, length or
// distance field or emits one byte at a time, since the window has a single
// read port and a single write port, and backpressure on the output stalls
// it. The window needs no clearing pass after reset.
module lzss_stream_decoder
  import lzss_pkg::*;
#(
  parameter int WINDOW_BITS  = 12,
  parameter int LENGTH_BITS  = 4,
  parameter int MATCH_OFFSET = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]        m_axis_tuser,   // [0] byte_valid, [1] stream_end
  output logic              m_axis_tlast    // run_last
);

  localparam int ACC_W  = WINDOW_BITS + 8;
  localparam int HELD_W = $clog2(WINDOW_BITS + 9);
  localparam int CNT_W  = LENGTH_BITS + 1;

  st_t    state, state_next;
  phase_t phase, phase_next;

  logic [LENGTH_BITS-1:0] pending, pending_next;
  logic [WINDOW_BITS-1:0] src, src_next;
  logic [CNT_W-1:0]       cnt, cnt_next;

  br_op_t            br_op;
  logic [ACC_W-1:0]  acc;
  logic [HELD_W-1:0] held;
  logic [HELD_W-1:0] rem;

  logic                   push;
  logic [BYTE_W-1:0]      push_data;
  logic                   rd_en;
  logic [WINDOW_BITS-1:0] rd_addr;
  logic [WINDOW_BITS-1:0] wp;
  logic [BYTE_W-1:0]      rd_data;

  logic              emit;
  logic [BYTE_W-1:0] e_byte;
  logic              e_valid;
  logic              e_end;
  logic              e_last;
  logic              out_free;

  logic have_flag, have_lit, have_len, have_dist, code_end, lit_more;

  lzss_bitrd #(
    .WINDOW_BITS(WINDOW_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_bitrd (
    .clk     (clk),
    .rst     (rst),
    .op      (br_op),
    .in_byte (s_axis_tdata),
    .acc     (acc),
    .held    (held)
  );

  lzss_window #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wp        (wp),
    .rd_data   (rd_data)
  );

  assign s_axis_tready = (state == ST_IDLE) || (state == ST_DONE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign have_flag = held >= HELD_W'(1);
  assign have_lit  = held >= HELD_W'(BYTE_W);
  assign have_len  = held >= HELD_W'(LENGTH_BITS);
  assign have_dist = held >= HELD_W'(WINDOW_BITS);
  assign code_end  = acc[LENGTH_BITS-1:0] == {LENGTH_BITS{1'b1}};

  // Does the token after this literal produce a word from the same byte?
  assign rem = held - HELD_W'(BYTE_W);
  always_comb begin
    lit_more = 1'b0;
    if (rem >= HELD_W'(1)) begin
      if (!acc[BYTE_W]) begin
        lit_more = rem >= HELD_W'(BYTE_W + 1);
      end else if (rem >= HELD_W'(LENGTH_BITS + 1)) begin
        lit_more = (acc[BYTE_W+LENGTH_BITS:BYTE_W+1] == {LENGTH_BITS{1'b1}}) ||
                   (rem >= HELD_W'(LENGTH_BITS + WINDOW_BITS + 1));
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (phase)
          PH_FLAG: if (!have_flag) state_next = ST_IDLE;
          PH_LIT:  if (!have_lit) state_next = ST_IDLE;
          PH_LEN: begin
            if (!have_len) begin
              state_next = ST_IDLE;
            end else if (code_end && out_free) begin
              state_next = ST_DONE;
            end
          end
          PH_DIST: state_next = have_dist ? ST_COPY : ST_IDLE;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_COPY: begin
        if (out_free && (cnt == CNT_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      ST_DONE: state_next = ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    br_op        = BR_NOP;
    push         = 1'b0;
    push_data    = acc[BYTE_W-1:0];
    rd_en        = 1'b0;
    rd_addr      = src;
    emit         = 1'b0;
    e_byte       = '0;
    e_valid      = 1'b0;
    e_end        = 1'b0;
    e_last       = 1'b0;
    phase_next   = phase;
    pending_next = pending;
    src_next     = src;
    cnt_next     = cnt;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          br_op = BR_LOAD;
        end
      end
      ST_DECODE: begin
        case (phase)
          PH_FLAG: begin
            if (have_flag) begin
              br_op      = BR_FLAG;
              phase_next = acc[0] ? PH_LEN : PH_LIT;
            end
          end
          PH_LIT: begin
            if (have_lit && out_free) begin
              br_op      = BR_LIT;
              push       = 1'b1;
              emit       = 1'b1;
              e_byte     = acc[BYTE_W-1:0];
              e_valid    = 1'b1;
              e_last     = !lit_more;
              phase_next = PH_FLAG;
            end
          end
          PH_LEN: begin
            if (have_len) begin
              if (code_end) begin
                if (out_free) begin
                  br_op      = BR_CLEAR;
                  emit       = 1'b1;
                  e_end      = 1'b1;
                  e_last     = 1'b1;
                  phase_next = PH_FLAG;
                end
              end else begin
                br_op        = BR_LEN;
                pending_next = acc[LENGTH_BITS-1:0];
                phase_next   = PH_DIST;
              end
            end
          end
          PH_DIST: begin
            if (have_dist) begin
              br_op      = BR_DIST;
              rd_en      = 1'b1;
              rd_addr    = wp - acc[WINDOW_BITS-1:0];
              src_next   = rd_addr + WINDOW_BITS'(1);
              cnt_next   = CNT_W'(pending) + CNT_W'(MATCH_OFFSET + 1);
              phase_next = PH_FLAG;
            end
          end
          default: phase_next = PH_FLAG;
        endcase
      end
      ST_COPY: begin
        // One window byte per cycle while the output is free: write the byte from the
        // last read and issue the next read in the same cycle.
        if (out_free) begin
          push      = 1'b1;
          push_data = rd_data;
          emit      = 1'b1;
          e_byte    = rd_data;
          e_valid   = 1'b1;
          e_last    = cnt == CNT_W'(1);
          cnt_next  = cnt - CNT_W'(1);
          if (cnt != CNT_W'(1)) begin
            rd_en    = 1'b1;
            rd_addr  = src;
            src_next = src + WINDOW_BITS'(1);
          end
        end
      end
      ST_DONE: begin
        br_op = BR_NOP;
      end
      default: begin
        br_op = BR_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      phase   <= PH_FLAG;
      pending <= '0;
      cnt     <= '0;
      src     <= '0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      pending <= pending_next;
      cnt     <= cnt_next;
      src     <= src_next;
    end
  end

  // Output register holds one word so field decoding keeps going while it waits; the next emitted word waits for it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= e_byte;
      m_axis_tuser <= {e_end, e_valid};
      m_axis_tlast <= e_last;
    end
  end

endmodule
